### sv/cmms_pkg.sv
// shared types and constants for the column min/max/null statistics core
package cmms_pkg;

  typedef enum logic [1:0] {
    VT_I32  = 2'd0,
    VT_I64  = 2'd1,
    VT_F64  = 2'd2,
    VT_BOOL = 2'd3
  } value_type_t;

  // true when a is strictly below b under type vt (stored marks are already masked)
  function automatic logic less_than(input logic [63:0] a, input logic [63:0] b,
                                     input value_type_t vt);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    res = 1'b0;
    case (vt)
      VT_I32:  res = $signed(a[31:0]) < $signed(b[31:0]);
      VT_I64:  res = $signed(a) < $signed(b);
      VT_F64: begin
        if (a_nan || b_nan || (a_zero && b_zero)) begin
          res = 1'b0;
        end else if (a[63] != b[63]) begin
          res = a[63];
        end else if (a[63]) begin
          res = a[62:0] > b[62:0];
        end else begin
          res = a[62:0] < b[62:0];
        end
      end
      VT_BOOL: res = a[0] < b[0];
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

### sv/column_min_max_null_stats_core.sv
// top level of the column min/max/null statistics core
// Streaming column statistics. Each input transaction carries one column
// entry (raw bits, null flag, restart flag); each accepted transaction yields
// exactly one output transaction with the updated any_null, saturating null
// count, any_value, min and max raw bits. Throughput is one transaction per
// clock while the skid slot is empty (s_tready drops while it is full): the
// statistics registers are updated by one compare-and-select per item, and a
// single output register with a skid stage holds results while the downstream
// side stalls. value_type (reset int64) may only be written while idle; a
// change does not clear the statistics.
module column_min_max_null_stats_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // config write channel: value_type in bits [1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // sample_bits
  input  logic [1:0]   s_tuser,   // [0] is_null, [1] restart
  output logic         m_tvalid,
  input  logic         m_tready,
  // any_null, nulls_seen[32], any_value, min_bits[64], max_bits[64], zero pad[6]
  output logic [167:0] m_tdata
);
  import cmms_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  value_type_t vt;
  logic null_flag;
  logic [COUNT_BITS-1:0] null_total;
  logic value_flag;
  logic [63:0] low_mark, high_mark;

  logic null_flag_next, value_flag_next;
  logic [COUNT_BITS-1:0] null_total_next;
  logic [63:0] low_mark_next, high_mark_next;

  // output register and skid slot
  logic out_valid, skid_valid;
  logic [167:0] out_data, skid_data;
  logic [167:0] res_data;

  logic s_fire;
  assign s_tready = !skid_valid;
  assign s_fire = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [63:0] smp;
    logic nul;
    logic fl;
    logic [COUNT_BITS-1:0] tot;
    logic vf;
    logic [63:0] lo, hi;
    fl = null_flag; tot = null_total; vf = value_flag; lo = low_mark; hi = high_mark;
    if (s_tuser[1]) begin
      fl = 1'b0; tot = '0; vf = 1'b0; lo = '0; hi = '0;
    end
    smp = s_tdata;
    nul = s_tuser[0];
    if (vt == VT_I32) smp = {32'd0, s_tdata[31:0]};
    else if (vt == VT_BOOL) smp = {63'd0, s_tdata[0]};
    else if (vt == VT_F64 && s_tdata[62:52] == 11'h7ff && s_tdata[51:0] != 52'd0) nul = 1'b1;
    null_flag_next = fl; null_total_next = tot; value_flag_next = vf;
    low_mark_next = lo; high_mark_next = hi;
    if (nul) begin
      null_flag_next = 1'b1;
      if (tot != CountMax) null_total_next = tot + 1'b1;
    end else if (!vf) begin
      low_mark_next = smp; high_mark_next = smp; value_flag_next = 1'b1;
    end else begin
      if (less_than(smp, lo, vt)) low_mark_next = smp;
      if (less_than(hi, smp, vt)) high_mark_next = smp;
    end
  end

  always_comb begin
    logic [31:0] cnt;
    // count shown in its low 32 bits, zero-extended when narrower
    cnt = 32'(null_total_next);
    res_data = {6'd0, high_mark_next, low_mark_next, value_flag_next, cnt, null_flag_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= VT_I64;
      null_flag <= 1'b0; null_total <= '0; value_flag <= 1'b0;
      low_mark <= '0; high_mark <= '0;
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (cfg_valid) vt <= value_type_t'(cfg_data);
      if (s_fire) begin
        null_flag <= null_flag_next; null_total <= null_total_next;
        value_flag <= value_flag_next;
        low_mark <= low_mark_next; high_mark <= high_mark_next;
      end
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid <= 1'b1; out_data <= skid_data; skid_valid <= 1'b0;
        end else begin
          out_valid <= s_fire; if (s_fire) out_data <= res_data;
        end
      end else if (s_fire) begin
        skid_valid <= 1'b1; skid_data <= res_data;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

`ifndef SYNTHESIS
  // skid slot only fills while the output stalls
  a_skid: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready)) else $error("skid fill");
  // an accepted item always lands in the output register or the skid slot next cycle
  a_out: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (m_tvalid || skid_valid)) else $error("lost item");
  // outside float64, a non-null, non-restart item leaves the null count alone
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_tuser[1] && !s_tuser[0] && vt != VT_F64) |=> $stable(null_total))
    else $error("count moved");
`endif
endmodule

### bench/column_min_max_null_stats_core_tb.sv
// testbench for the column min/max/null statistics core
`timescale 1ns / 1ps

module column_min_max_null_stats_core_tb;
  import cmms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        any_null;
    logic [31:0] nulls_seen;
    logic        any_value;
    logic [63:0] min_bits;
    logic [63:0] max_bits;
  } col_stats_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;

  // predictor state
  value_type_t  cur_type;
  logic         seen_null;
  logic [31:0]  null_tally;
  logic         seen_value;
  logic [63:0]  low_val;
  logic [63:0]  high_val;

  col_stats_t   stats_q[$];
  int           send_gap_pct;
  int           recv_stall_pct;
  int           cycles;
  bit           failed;

  column_min_max_null_stats_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit f64_nan(logic [63:0] b);
    return (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
  endfunction

  function automatic bit below(logic [63:0] a, logic [63:0] b);
    case (cur_type)
      VT_I32:  return $signed(a[31:0]) < $signed(b[31:0]);
      VT_I64:  return $signed(a) < $signed(b);
      VT_F64:  return !f64_nan(a) && !f64_nan(b) && ($bitstoreal(a) < $bitstoreal(b));
      default: return a[0] < b[0];
    endcase
  endfunction

  task automatic fold_entry(input logic [63:0] raw, input logic nul, input logic rs);
    logic [63:0] v;
    col_stats_t  e;
    v = raw;
    if (rs) begin
      seen_null = 0; null_tally = 0; seen_value = 0; low_val = 0; high_val = 0;
    end
    if (cur_type == VT_I32) v = {32'd0, raw[31:0]};
    else if (cur_type == VT_BOOL) v = {63'd0, raw[0]};
    else if (cur_type == VT_F64 && f64_nan(raw)) nul = 1'b1;
    if (nul) begin
      seen_null = 1'b1;
      if (null_tally != 32'hffff_ffff) null_tally = null_tally + 32'd1;
    end else if (!seen_value) begin
      low_val = v; high_val = v; seen_value = 1'b1;
    end else begin
      if (below(v, low_val)) low_val = v;
      if (below(high_val, v)) high_val = v;
    end
    e.any_null = seen_null; e.nulls_seen = null_tally; e.any_value = seen_value;
    e.min_bits = low_val; e.max_bits = high_val;
    stats_q = {stats_q, e};
  endtask

  // predictor and scoreboard, sampled on the rising edge
  always @(posedge clk) begin
    col_stats_t e;
    cycles <= cycles + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready) cur_type = value_type_t'(cfg_data);
      if (s_tvalid && s_tready) fold_entry(s_tdata, s_tuser[0], s_tuser[1]);
      if (m_tvalid && m_tready) begin
        if (stats_q.size() == 0) begin
          $error("unexpected output transaction");
          failed = 1;
        end else begin
          e = stats_q.pop_front();
          if (m_tdata[0] !== e.any_null) begin
            $error("any_null exp %0d got %0d", e.any_null, m_tdata[0]); failed = 1;
          end
          if (m_tdata[32:1] !== e.nulls_seen) begin
            $error("nulls_seen exp %0d got %0d", e.nulls_seen, m_tdata[32:1]); failed = 1;
          end
          if (m_tdata[33] !== e.any_value) begin
            $error("any_value exp %0d got %0d", e.any_value, m_tdata[33]); failed = 1;
          end
          if (m_tdata[97:34] !== e.min_bits) begin
            $error("min_bits exp %h got %h", e.min_bits, m_tdata[97:34]); failed = 1;
          end
          if (m_tdata[161:98] !== e.max_bits) begin
            $error("max_bits exp %h got %h", e.max_bits, m_tdata[161:98]); failed = 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_entry(input logic [63:0] raw, input logic nul, input logic rs);
    @(negedge clk);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = raw;
    s_tuser = {rs, nul};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_type(input value_type_t vt);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = vt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [63:0] pick_sample;
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {32'd0, 32'h8000_0000} | ({$urandom, 32'd0});
      3: return {$urandom, 32'h7fff_ffff};
      4: return {$urandom_range(1) ? 32'hffff_ffff : 32'd0, 32'($urandom_range(20)) - 10};
      5: return {1'($urandom_range(1)), 11'h7ff, 20'($urandom), $urandom};   // nan or inf
      6: return {1'($urandom_range(1)), 63'd0};                               // signed zeros
      7: return {1'($urandom_range(1)), 11'($urandom_range(1020, 1030)), 20'($urandom),
                 $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // int64 (reset type): extremes, first value, nulls, restart
  task automatic test_int64_directed;
    send_entry(64'h0000_0000_0000_0005, 1'b1, 1'b0);   // null before any value
    send_entry(64'h0000_0000_0000_0005, 1'b0, 1'b0);
    send_entry(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send_entry(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
    send_entry(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);   // restart
    send_entry(64'd0, 1'b1, 1'b1);
  endtask

  task automatic test_int32_directed;
    write_type(VT_I32);
    send_entry(64'hffff_ffff_0000_0003, 1'b0, 1'b1);   // upper half ignored
    send_entry(64'h0000_0000_8000_0000, 1'b0, 1'b0);
    send_entry(64'h1234_5678_7fff_ffff, 1'b0, 1'b0);
    send_entry(64'hdead_beef_0000_0000, 1'b1, 1'b0);
  endtask

  task automatic test_f64_directed;
    write_type(VT_F64);
    send_entry(64'h8000_0000_0000_0000, 1'b0, 1'b1);   // -0.0 first
    send_entry(64'h0000_0000_0000_0000, 1'b0, 1'b0);   // +0.0 equal, keeps -0.0
    send_entry(64'h7ff8_0000_0000_0001, 1'b0, 1'b0);   // nan counts as null
    send_entry(64'hfff0_0000_0000_0000, 1'b0, 1'b0);   // -inf
    send_entry(64'h7ff0_0000_0000_0000, 1'b0, 1'b0);   // +inf
    send_entry(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);   // negative nan
  endtask

  task automatic test_bool_directed;
    write_type(VT_BOOL);
    send_entry(64'hffff_ffff_ffff_fffe, 1'b0, 1'b1);   // only bit 0 counts
    send_entry(64'h0000_0000_0000_0001, 1'b0, 1'b0);
    send_entry(64'h0000_0000_0000_0001, 1'b1, 1'b0);
    // type change keeps the stored marks
    write_type(VT_I64);
    send_entry(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
  endtask

  task automatic test_random_stream;
    int phase;
    int chunk;
    int k;
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
      recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
      for (chunk = 0; chunk < 6; chunk++) begin
        write_type(value_type_t'($urandom_range(3)));
        for (k = 0; k < 60; k++)
          send_entry(pick_sample(), $urandom_range(99) < 15, $urandom_range(99) < 4);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    m_tready = 1'b0;
    send_gap_pct = 0; recv_stall_pct = 0;
    cycles = 0; failed = 0;
    cur_type = VT_I64;
    seen_null = 0; null_tally = 0; seen_value = 0; low_val = 0; high_val = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_int64_directed();
    test_int32_directed();
    test_f64_directed();
    test_bool_directed();
    test_random_stream();
    settle();
    repeat (5) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
